>>> sv/irlt_pkg.sv
// Types, constants and helpers shared by the IR ranging level tracker.
package irlt_pkg;

  typedef logic [7:0] level_t;
  typedef logic [8:0] tick_t;
  typedef logic signed [9:0] wide_level_t;

  typedef enum logic [1:0] {
    CH_RIGHT  = 2'd0,
    CH_CENTRE = 2'd1,
    CH_LEFT   = 2'd2
  } chan_t;

  localparam int unsigned ChCount = 3;

  // Configuration register indexes
  localparam logic CFG_SAMPLE_POINT = 1'b0;
  localparam logic CFG_MAX_LEVEL    = 1'b1;

  localparam level_t SamplePointRst = 8'd20;
  localparam level_t MaxLevelRst    = 8'd100;

  localparam level_t LowStepLimit = 8'd10;
  // x/5 as (x*205)>>10, exact for every 8-bit x
  localparam logic [7:0] Div5Mul   = 8'd205;
  localparam int unsigned Div5Shift = 10;

  // Clamp to max_lv first, then raise to at least 1
  function automatic level_t clamp_level(input wide_level_t v, input level_t max_lv);
    wide_level_t t;
    wide_level_t lim;
    lim = $signed({2'b00, max_lv});
    t   = v;
    if (t > lim) t = lim;
    if (t < 10'sd1) t = 10'sd1;
    return t[7:0];
  endfunction

endpackage

>>> sv/irlt_level_step.sv
// Level step at the sample tick: +-1 below ten, otherwise +-level/5 (centre down: level/4).
module irlt_level_step (
  input  irlt_pkg::level_t level_in,
  input  logic             rx_bit,
  input  logic             centre,
  input  irlt_pkg::level_t max_level,
  output irlt_pkg::level_t level_out
);
  import irlt_pkg::*;

  logic [15:0] prod5;
  level_t      div5;
  level_t      div4;
  level_t      down_step;
  wide_level_t lv_ext;
  wide_level_t stepped;

  assign prod5     = level_in * Div5Mul;
  assign div5      = 8'(prod5 >> Div5Shift);
  assign div4      = level_in >> 2;
  assign down_step = centre ? div4 : div5;
  assign lv_ext    = $signed({2'b00, level_in});

  always_comb begin
    if (rx_bit) begin
      if (level_in < LowStepLimit) stepped = lv_ext + 10'sd1;
      else                         stepped = lv_ext + $signed({2'b00, div5});
    end else begin
      if (level_in < LowStepLimit) stepped = lv_ext - 10'sd1;
      else                         stepped = lv_ext - $signed({2'b00, down_step});
    end
  end

  assign level_out = clamp_level(stepped, max_level);

endmodule

>>> sv/ir_ranging_level_tracker.sv
// Top level of the three-channel IR ranging level tracker.
// Throughput: one item per cycle; the input register and the state/result
// registers form a two-stage pipeline, stalled only by out_ready.
// Reset: levels, drives, slot tick and channel clear to zero;
// sample_point returns to 20 and max_level to 100.
module ir_ranging_level_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_rx_right,
  input  logic             in_rx_centre,
  input  logic             in_rx_left,
  output logic             out_valid,
  input  logic             out_ready,
  output irlt_pkg::level_t out_drive_right,
  output irlt_pkg::level_t out_drive_centre,
  output irlt_pkg::level_t out_drive_left,
  output irlt_pkg::level_t out_level_right,
  output irlt_pkg::level_t out_level_centre,
  output irlt_pkg::level_t out_level_left,
  output logic [1:0]       out_active_channel,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data
);
  import irlt_pkg::*;

  logic       in_valid_r;
  logic [2:0] rx_r;
  logic       out_valid_r;
  logic       advance;

  level_t sample_point_r;
  level_t max_level_r;
  tick_t  tick_r, tick_nxt;
  chan_t  chan_r, chan_nxt;
  level_t level_r   [ChCount];
  level_t level_nxt [ChCount];
  level_t cmp_r     [ChCount];
  level_t cmp_nxt   [ChCount];

  logic   at_load;
  logic   at_sample;
  logic   rx_sel;
  level_t level_sel;
  level_t level_stepped;
  tick_t  tick_inc;
  logic   slot_end;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // Handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) rx_r <= {in_rx_left, in_rx_centre, in_rx_right};
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_point_r <= SamplePointRst;
      max_level_r    <= MaxLevelRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SAMPLE_POINT: sample_point_r <= cfg_data;
        CFG_MAX_LEVEL:    max_level_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign at_load   = (tick_r == '0);
  assign at_sample = (tick_r == {1'b0, sample_point_r});

  always_comb begin
    case (chan_r)
      CH_RIGHT: begin
        rx_sel    = rx_r[0];
        level_sel = level_r[0];
      end
      CH_CENTRE: begin
        rx_sel    = rx_r[1];
        level_sel = level_r[1];
      end
      CH_LEFT: begin
        rx_sel    = rx_r[2];
        level_sel = level_r[2];
      end
      default: begin
        rx_sel    = 1'b0;
        level_sel = level_r[0];
      end
    endcase
  end

  irlt_level_step u_step (
    .level_in  (level_sel),
    .rx_bit    (rx_sel),
    .centre    (chan_r == CH_CENTRE),
    .max_level (max_level_r),
    .level_out (level_stepped)
  );

  always_comb begin
    for (int i = 0; i < ChCount; i++) begin
      // Load the owner's drive at slot start, clear the others
      if (at_load) cmp_nxt[i] = (2'(i) == chan_r) ? level_r[i] : '0;
      else         cmp_nxt[i] = cmp_r[i];
      level_nxt[i] = level_r[i];
      if (at_sample && (2'(i) == chan_r)) begin
        cmp_nxt[i]   = '0;
        level_nxt[i] = level_stepped;
      end
      level_nxt[i] = clamp_level($signed({2'b00, level_nxt[i]}), max_level_r);
    end
  end

  assign tick_inc = tick_r + 9'd1;
  assign slot_end = (tick_inc >= {sample_point_r, 1'b0});
  assign tick_nxt = slot_end ? '0 : tick_inc;

  always_comb begin
    if (!slot_end) begin
      chan_nxt = chan_r;
    end else begin
      case (chan_r)
        CH_RIGHT:  chan_nxt = CH_CENTRE;
        CH_CENTRE: chan_nxt = CH_LEFT;
        default:   chan_nxt = CH_RIGHT;
      endcase
    end
  end

  // Tracker state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      chan_r <= CH_RIGHT;
      for (int i = 0; i < ChCount; i++) begin
        level_r[i] <= '0;
        cmp_r[i]   <= '0;
      end
    end else if (advance) begin
      tick_r <= tick_nxt;
      chan_r <= chan_nxt;
      for (int i = 0; i < ChCount; i++) begin
        level_r[i] <= level_nxt[i];
        cmp_r[i]   <= cmp_nxt[i];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_right    = cmp_r[0];
  assign out_drive_centre   = cmp_r[1];
  assign out_drive_left     = cmp_r[2];
  assign out_level_right    = level_r[0];
  assign out_level_centre   = level_r[1];
  assign out_level_left     = level_r[2];
  assign out_active_channel = chan_r;

  // At most one emitter is driven at any time
  a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmp_r[0] != '0, cmp_r[1] != '0, cmp_r[2] != '0}) <= 1)
    else $error("more than one emitter driven");

  // Every delivered level is clamped to at least one
  a_level_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (level_r[0] != '0 && level_r[1] != '0 && level_r[2] != '0))
    else $error("level below one on result");

  // Tracker state holds whenever no item advances, stalled or idle
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(chan_r) && $stable(tick_r)))
    else $error("state moved without an item");

  // A stalled item stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("stalled item dropped");

  // A result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(level_r[0])))
    else $error("pending result lost");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the three-channel IR ranging level tracker.
module tb_top;
  import irlt_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int StepDiv       = 5;
  localparam int StepDivCentre = 4;

  typedef struct {
    level_t     drive_right;
    level_t     drive_centre;
    level_t     drive_left;
    level_t     level_right;
    level_t     level_centre;
    level_t     level_left;
    logic [1:0] active_channel;
  } tick_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_rx_right = 1'b0;
  logic       in_rx_centre = 1'b0;
  logic       in_rx_left = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  level_t     out_drive_right;
  level_t     out_drive_centre;
  level_t     out_drive_left;
  level_t     out_level_right;
  level_t     out_level_centre;
  level_t     out_level_left;
  logic [1:0] out_active_channel;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_SAMPLE_POINT;
  logic [7:0] cfg_data = 8'd0;

  // Tracker state as the checker sees it
  level_t     sample_pt = SamplePointRst;
  level_t     max_lvl = MaxLevelRst;
  tick_t      slot_pos = '0;
  logic [1:0] cur_chan = CH_RIGHT;
  level_t     levels [ChCount] = '{default: 8'd0};
  level_t     drives [ChCount] = '{default: 8'd0};

  tick_result_t expected_ticks [$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           idling_on = 1'b1;
  int unsigned  stall_left = 0;

  ir_ranging_level_tracker uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_right        (in_rx_right),
    .in_rx_centre       (in_rx_centre),
    .in_rx_left         (in_rx_left),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive_right    (out_drive_right),
    .out_drive_centre   (out_drive_centre),
    .out_drive_left     (out_drive_left),
    .out_level_right    (out_level_right),
    .out_level_centre   (out_level_centre),
    .out_level_left     (out_level_left),
    .out_active_channel (out_active_channel),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the tracker by one tick; rx[0] right, rx[1] centre, rx[2] left
  function automatic tick_result_t track_tick(input logic [2:0] rx);
    tick_result_t r;
    int lv;
    int c;
    c = int'(cur_chan);
    if (slot_pos == '0) begin
      for (int i = 0; i < ChCount; i++) drives[i] = (i == c) ? levels[i] : 8'd0;
    end
    if (slot_pos == {1'b0, sample_pt}) begin
      lv = int'(levels[c]);
      if (rx[c]) begin
        lv = (lv < int'(LowStepLimit)) ? lv + 1 : lv + lv / StepDiv;
      end else if (lv < int'(LowStepLimit)) begin
        lv = lv - 1;
      end else begin
        lv = lv - lv / ((c == int'(CH_CENTRE)) ? StepDivCentre : StepDiv);
      end
      if (lv > int'(max_lvl)) lv = int'(max_lvl);
      if (lv < 1) lv = 1;
      levels[c] = lv[7:0];
      drives[c] = 8'd0;
    end
    slot_pos = slot_pos + 9'd1;
    // a shrunk sample point ends the slot at once
    if (int'(slot_pos) >= 2 * int'(sample_pt)) begin
      slot_pos = '0;
      cur_chan = (cur_chan == CH_LEFT) ? CH_RIGHT : cur_chan + 2'd1;
    end
    for (int i = 0; i < ChCount; i++) begin
      if (levels[i] > max_lvl) levels[i] = max_lvl;
      if (levels[i] < 8'd1) levels[i] = 8'd1;
    end
    r.drive_right    = drives[CH_RIGHT];
    r.drive_centre   = drives[CH_CENTRE];
    r.drive_left     = drives[CH_LEFT];
    r.level_right    = levels[CH_RIGHT];
    r.level_centre   = levels[CH_CENTRE];
    r.level_left     = levels[CH_LEFT];
    r.active_channel = cur_chan;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Check results first: a result never comes in the cycle its item is taken
  always @(posedge clk) begin
    tick_result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          $error("result with no item pending");
          fail_count++;
        end else begin
          e = expected_ticks.pop_front();
          check_field("drive_right", e.drive_right, out_drive_right);
          check_field("drive_centre", e.drive_centre, out_drive_centre);
          check_field("drive_left", e.drive_left, out_drive_left);
          check_field("level_right", e.level_right, out_level_right);
          check_field("level_centre", e.level_centre, out_level_centre);
          check_field("level_left", e.level_left, out_level_left);
          check_field("active_channel", e.active_channel, out_active_channel);
        end
      end
      if (in_valid && in_ready)
        expected_ticks.push_back(track_tick({in_rx_left, in_rx_centre, in_rx_right}));
    end
  end

  // Receiver stalls at random, in bursts of random length, while idling_on is set
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && rst_n && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ir_ranging_level_tracker verification failed");
      $finish;
    end
  end

  task automatic send_tick(input logic rx_r, input logic rx_c, input logic rx_l);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_rx_right  = rx_r;
    in_rx_centre = rx_c;
    in_rx_left   = rx_l;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input level_t val);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SAMPLE_POINT) sample_pt = val;
    else max_lvl = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver bits set with the given percentage
  task automatic run_ticks(input int count, input int up_pct);
    repeat (count)
      send_tick($urandom_range(0, 99) < up_pct, $urandom_range(0, 99) < up_pct,
                $urandom_range(0, 99) < up_pct);
  endtask

  task automatic test_reset_state();
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_fast_slots();
    write_reg(CFG_SAMPLE_POINT, 8'd1);
    write_reg(CFG_MAX_LEVEL, 8'd255);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
  endtask

  // Load and sample on the same tick; zero max level forces every level to 1
  task automatic test_zero_sample_point();
    write_reg(CFG_SAMPLE_POINT, 8'd0);
    write_reg(CFG_MAX_LEVEL, 8'd0);
    repeat (4) send_tick(1'b1, 1'b1, 1'b1);
    write_reg(CFG_MAX_LEVEL, 8'd10);
    repeat (4) send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_sample_point_change();
    write_reg(CFG_SAMPLE_POINT, 8'd8);
    run_ticks(10, 50);
    // slot tick is past the new slot length: slot ends on the next tick
    write_reg(CFG_SAMPLE_POINT, 8'd3);
    run_ticks(3, 50);
  endtask

  task automatic test_random_ramps();
    write_reg(CFG_SAMPLE_POINT, 8'd2);
    write_reg(CFG_MAX_LEVEL, 8'd255);
    run_ticks(60, 90);
    run_ticks(40, 10);
    write_reg(CFG_SAMPLE_POINT, 8'd1);
    write_reg(CFG_MAX_LEVEL, 8'd10);
    run_ticks(30, 50);
    write_reg(CFG_SAMPLE_POINT, SamplePointRst);
    write_reg(CFG_MAX_LEVEL, MaxLevelRst);
    run_ticks(80, 85);
    write_reg(CFG_SAMPLE_POINT, 8'd255);
    write_reg(CFG_MAX_LEVEL, 8'd200);
    run_ticks(25, 50);
    write_reg(CFG_SAMPLE_POINT, 8'd4);
    run_ticks(20, 50);
  endtask

  task automatic test_random_settings();
    idling_on = 1'b0;
    repeat (4) begin
      write_reg(CFG_SAMPLE_POINT, level_t'($urandom_range(0, 7)));
      write_reg(CFG_MAX_LEVEL, level_t'($urandom_range(0, 255)));
      run_ticks(30, $urandom_range(10, 90));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_fast_slots();
    test_zero_sample_point();
    test_sample_point_change();
    test_random_ramps();
    test_random_settings();
    drain_results();
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("ir_ranging_level_tracker verification clean");
    end else begin
      $display("ir_ranging_level_tracker verification failed");
    end
    $finish;
  end

endmodule
